// File: sv/sbr_pkg.sv
`default_nettype none

package sbr_pkg;

  localparam int unsigned SIZE_BYTES = 4;
  localparam int unsigned SIZE_CNT_W = $clog2(SIZE_BYTES);
  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned IDX_W = $clog2(MAX_RESULTS);

  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd8388608;

  localparam logic [7:0] REQUEST_BYTE = 8'h03;
  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_E = 8'h45;
  localparam logic [7:0] CHAR_O = 8'h4f;
  localparam logic [7:0] CHAR_K = 8'h4b;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SIZE,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    RPL_REQ,
    RPL_OK,
    RPL_ERR,
    RPL_STORE
  } reply_code_t;

  // one accepted item's worth of output, expanded by the emitter
  typedef struct packed {
    logic        valid;
    reply_code_t code;
    logic [7:0]  data;
    logic [31:0] offset;
    logic        complete;
  } reply_t;

  function automatic logic [IDX_W-1:0] reply_len(reply_code_t code);
    logic [IDX_W-1:0] n;
    begin
      unique case (code)
        RPL_REQ:   n = IDX_W'(3);
        RPL_OK:    n = IDX_W'(2);
        RPL_ERR:   n = IDX_W'(MAX_RESULTS);
        RPL_STORE: n = IDX_W'(1);
        default:   n = IDX_W'(1);
      endcase
      return n;
    end
  endfunction

  function automatic logic [7:0] reply_byte(reply_code_t code, logic [IDX_W-1:0] idx,
                                            logic [7:0] data);
    logic [7:0] b;
    begin
      unique case (code)
        RPL_REQ:   b = REQUEST_BYTE;
        RPL_OK:    b = (idx == '0) ? CHAR_O : CHAR_K;
        RPL_ERR: begin
          if (idx == IDX_W'(0)) b = CHAR_S;
          else if (idx == IDX_W'(1)) b = CHAR_E;
          else b = REQUEST_BYTE;
        end
        RPL_STORE: b = data;
        default:   b = data;
      endcase
      return b;
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/sbr_core.sv
`default_nettype none

module sbr_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_wr_en,
  input  wire logic [31:0]    cfg_wr_data,
  input  wire logic           accept,
  input  wire logic           command,
  input  wire logic [7:0]     rx_byte,
  output sbr_pkg::reply_t     reply
);
  import sbr_pkg::*;

  logic [31:0]           max_payload;
  phase_t                phase, phase_next;
  logic [SIZE_CNT_W-1:0] size_cnt, size_cnt_next;
  logic [31:0]           size_acc, size_acc_next;
  logic [31:0]           rcv, rcv_next;

  logic [31:0] acc_merged;
  logic [31:0] rcv_inc;
  logic        size_full;
  logic        size_bad;
  logic        fin;

  // lanes above the current byte are still zero, so or-ing places the byte
  assign acc_merged = size_acc | (32'(rx_byte) << {size_cnt, 3'b000});
  assign size_full  = (size_cnt == SIZE_CNT_W'(SIZE_BYTES - 1));
  assign size_bad   = (acc_merged == '0) || (acc_merged > max_payload);
  assign rcv_inc    = rcv + 32'd1;
  assign fin        = (rcv_inc == size_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      size_cnt <= '0;
      size_acc <= '0;
      rcv      <= '0;
    end else begin
      phase    <= phase_next;
      size_cnt <= size_cnt_next;
      size_acc <= size_acc_next;
      rcv      <= rcv_next;
    end
  end

  always_comb begin
    phase_next    = phase;
    size_cnt_next = size_cnt;
    size_acc_next = size_acc;
    rcv_next      = rcv;
    if (accept) begin
      if (command == CMD_START) begin
        phase_next    = PH_SIZE;
        size_cnt_next = '0;
        size_acc_next = '0;
        rcv_next      = '0;
      end else begin
        unique case (phase)
          PH_SIZE: begin
            size_acc_next = acc_merged;
            size_cnt_next = size_cnt + SIZE_CNT_W'(1);
            if (size_full) begin
              if (size_bad) begin
                size_acc_next = '0;
              end else begin
                rcv_next   = '0;
                phase_next = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            rcv_next = rcv_inc;
            if (fin) phase_next = PH_DONE;
          end
          PH_IDLE, PH_DONE: ;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    reply = '0;
    if (accept) begin
      if (command == CMD_START) begin
        reply.valid = 1'b1;
        reply.code  = RPL_REQ;
      end else begin
        unique case (phase)
          PH_SIZE: begin
            if (size_full) begin
              reply.valid = 1'b1;
              reply.code  = size_bad ? RPL_ERR : RPL_OK;
            end
          end
          PH_PAYLOAD: begin
            reply.valid    = 1'b1;
            reply.code     = RPL_STORE;
            reply.data     = rx_byte;
            reply.offset   = rcv;
            reply.complete = fin;
          end
          PH_IDLE, PH_DONE: ;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/sbr_emitter.sv
`default_nettype none

module sbr_emitter (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sbr_pkg::reply_t reply,
  output logic                 ready,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [39:0]          m_axis_tdata,
  output logic [1:0]           m_axis_tuser,
  output logic                 m_axis_tlast
);
  import sbr_pkg::*;

  logic             pend_valid;
  reply_t           pend;
  logic [IDX_W-1:0] idx;

  logic             out_free;
  logic             move;
  logic             pend_last;
  logic [7:0]       cur_byte;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign move      = pend_valid && out_free;
  assign pend_last = (idx == reply_len(pend.code) - IDX_W'(1));
  assign cur_byte  = reply_byte(pend.code, idx, pend.data);

  // a new transaction may enter as the final result of the pending one moves out
  assign ready = !pend_valid || (pend_last && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid    <= 1'b0;
      idx           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (move) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      // a new reply only arrives while the pending one is empty or on its final result
      if (reply.valid) begin
        pend_valid <= 1'b1;
        idx        <= '0;
      end else if (move) begin
        if (pend_last) pend_valid <= 1'b0;
        else idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (reply.valid) pend <= reply;
    if (move) begin
      if (pend.code == RPL_STORE) begin
        m_axis_tdata <= {pend.offset, cur_byte};
        m_axis_tuser <= {pend.complete, KIND_STORE};
      end else begin
        m_axis_tdata <= {32'd0, cur_byte};
        m_axis_tuser <= {1'b0, KIND_TX};
      end
      m_axis_tlast <= pend_last;
    end
  end

endmodule

`default_nettype wire

// File: sv/serial_boot_receiver_unit.sv
`default_nettype none

// Serial boot receiver. A start transaction (tuser 0) sends three 0x03 requests and
// arms size reception; four byte transactions (tuser 1) give the payload size, little
// endian. A size of zero or above max_payload_bytes answers 'S','E' and three fresh
// requests; a valid size answers 'O','K' and each following byte comes out as a store
// result with its offset, the final one flagged complete. Bytes are ignored while idle
// or done. An input item's results, 0 to 5 of them, leave the output register one per cycle
// while m_axis_tready is held high; payload bytes stream at one per cycle unless the output
// stalls. The result emitter holds one item: the next item is accepted in the cycle its
// predecessor's final result enters the output register. An accepted item is first held
// in the emitter's pending register, then its first result moves into the output register.
module serial_boot_receiver_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,     // max_payload_bytes
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,    // rx_byte
  input  wire logic        s_axis_tuser,    // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,    // byte_value [7:0], store_offset [39:8]
  output logic [1:0]       m_axis_tuser,    // kind [0], complete [1]
  output logic             m_axis_tlast
);
  import sbr_pkg::*;

  logic   accept;
  reply_t reply;

  assign accept = s_axis_tvalid && s_axis_tready;

  sbr_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .command     (s_axis_tuser),
    .rx_byte     (s_axis_tdata),
    .reply       (reply)
  );

  sbr_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .reply         (reply),
    .ready         (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // a start produces several results, so input must pause right after it
  a_start_blocks: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tuser == CMD_START) |=> !s_axis_tready)
    else $error("input taken while request bytes still pending");

  a_store_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0] == KIND_STORE) |-> m_axis_tlast)
    else $error("store result not flagged last");

  a_tx_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0] == KIND_TX)
      |-> (m_axis_tdata[39:8] == 32'd0 && !m_axis_tuser[1]))
    else $error("transmit result carries offset or complete");

endmodule

`default_nettype wire

// File: tb/tb_serial_boot_receiver_unit.sv
`default_nettype none

module tb_serial_boot_receiver_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sbr_pkg::*;

  typedef struct {
    logic        kind;
    logic [7:0]  value;
    logic [31:0] offset;
    logic        complete;
    logic        last;
  } boot_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = CMD_START;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  serial_boot_receiver_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk = ~clk;

  // receiver state as the testbench expects it
  phase_t      exp_phase = PH_IDLE;
  logic [1:0]  exp_size_cnt = '0;
  logic [31:0] exp_size = '0;
  logic [31:0] exp_stored = '0;
  logic [31:0] exp_limit = MAX_PAYLOAD_RESET;

  boot_reply_t pending_replies[$];

  bit idle_on = 1'b1;
  int error_count = 0;
  int stim_items = 0;
  int results_checked = 0;
  int limits_used = 0;
  int stall_left = 0;
  int run_left = 0;

  function automatic void push_reply(logic kind, logic [7:0] value, logic [31:0] offset,
                                     logic complete, logic last);
    boot_reply_t r;
    r.kind = kind;
    r.value = value;
    r.offset = offset;
    r.complete = complete;
    r.last = last;
    pending_replies.push_back(r);
  endfunction

  function automatic void push_requests();
    push_reply(KIND_TX, REQUEST_BYTE, '0, 1'b0, 1'b0);
    push_reply(KIND_TX, REQUEST_BYTE, '0, 1'b0, 1'b0);
    push_reply(KIND_TX, REQUEST_BYTE, '0, 1'b0, 1'b1);
  endfunction

  // returns 1 when the byte is dropped by the block
  function automatic bit predict_replies(logic cmd, logic [7:0] rx);
    logic fin;
    if (cmd == CMD_START) begin
      exp_phase = PH_SIZE;
      exp_size_cnt = '0;
      exp_size = '0;
      exp_stored = '0;
      push_requests();
    end else if (exp_phase == PH_SIZE) begin
      exp_size = exp_size | (32'(rx) << (8 * exp_size_cnt));
      exp_size_cnt = exp_size_cnt + 2'd1;
      if (exp_size_cnt == 2'd0) begin
        if (exp_size == '0 || exp_size > exp_limit) begin
          push_reply(KIND_TX, CHAR_S, '0, 1'b0, 1'b0);
          push_reply(KIND_TX, CHAR_E, '0, 1'b0, 1'b0);
          push_requests();
          exp_size = '0;
        end else begin
          push_reply(KIND_TX, CHAR_O, '0, 1'b0, 1'b0);
          push_reply(KIND_TX, CHAR_K, '0, 1'b0, 1'b1);
          exp_stored = '0;
          exp_phase = PH_PAYLOAD;
        end
      end
    end else if (exp_phase == PH_PAYLOAD) begin
      fin = (exp_stored + 32'd1) == exp_size;
      push_reply(KIND_STORE, rx, exp_stored, fin, 1'b1);
      exp_stored = exp_stored + 32'd1;
      if (fin) exp_phase = PH_DONE;
    end else begin
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : check_replies
    boot_reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t ns: result with none expected, got tdata 0x%0h tuser 0x%0h tlast %0b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        check_field("kind", want.kind, m_axis_tuser[0]);
        check_field("byte_value", want.value, m_axis_tdata[7:0]);
        check_field("store_offset", want.offset, m_axis_tdata[39:8]);
        check_field("complete", want.complete, m_axis_tuser[1]);
        check_field("last", want.last, m_axis_tlast);
        results_checked++;
      end
    end
  end

  // output back-pressure: stall bursts between runs of varying length, none while idle_on is clear
  always @(posedge clk) begin
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (run_left != 0) begin
      m_axis_tready <= 1'b1;
      run_left--;
    end else begin
      if ($urandom_range(0, 2) == 0) run_left = $urandom_range(20, 60);
      else run_left = $urandom_range(0, 6);
      stall_left = $urandom_range(1, 13);
      m_axis_tready <= 1'b1;
    end
  end

  // valid stays high into the next transaction unless a gap is taken
  task automatic send_item(input logic cmd, input logic [7:0] rx);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= rx;
    do @(posedge clk); while (!s_axis_tready);
    if (!predict_replies(cmd, rx)) stim_items++;
  endtask

  task automatic send_size(input logic [31:0] size);
    for (int i = 0; i < 4; i++) send_item(CMD_BYTE, size[8*i +: 8]);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    // trailing size bytes give no result but may still be in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    exp_limit = value;
    limits_used++;
  endtask

  task automatic run_session();
    int pick;
    int tries;
    int nbytes;
    int cap;
    logic [31:0] size;
    logic [31:0] upper;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      repeat ($urandom_range(1, 3)) send_item(CMD_BYTE, 8'($urandom));
    end else begin
      send_item(CMD_START, 8'($urandom));
      if (pick == 2) begin
        // size cut short; a later start aborts it, or later bytes complete it
        repeat ($urandom_range(1, 3)) send_item(CMD_BYTE, 8'($urandom));
      end else begin
        tries = 0;
        do begin
          upper = (exp_limit == '0) ? 32'd1 : ((exp_limit > 32'd12) ? 32'd12 : exp_limit);
          case ($urandom_range(0, 9))
            0: size = '0;
            1: size = $urandom;
            2: size = exp_limit + 32'd1;
            3: size = exp_limit;
            default: size = $urandom_range(1, upper);
          endcase
          send_size(size);
          tries++;
        end while (exp_phase == PH_SIZE && tries < 3);
        if (exp_phase == PH_PAYLOAD) begin
          cap = (exp_size > 32'd16) ? 16 : int'(exp_size);
          case ($urandom_range(0, 5))
            0: nbytes = $urandom_range(0, cap - 1);
            1: nbytes = cap + $urandom_range(1, 3);
            default: nbytes = cap;
          endcase
          repeat (nbytes) send_item(CMD_BYTE, 8'($urandom));
        end
      end
    end
  endtask

  task automatic test_reset_limit();
    send_item(CMD_BYTE, 8'hff);
    send_item(CMD_START, 8'h00);
    send_size(MAX_PAYLOAD_RESET + 32'd1);
    send_size(MAX_PAYLOAD_RESET);
    send_item(CMD_BYTE, 8'ha5);
    send_item(CMD_START, 8'hff);
  endtask

  task automatic test_limit_extremes();
    write_limit(32'd1);
    send_item(CMD_START, 8'h00);
    send_size(32'd0);
    send_size(32'd1);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'h5a);
    write_limit(32'd0);
    send_item(CMD_START, 8'h00);
    send_size(32'd1);
    write_limit(32'hffff_ffff);
    send_item(CMD_START, 8'h00);
    send_size(32'hffff_ffff);
    send_item(CMD_BYTE, 8'hff);
    send_item(CMD_BYTE, 8'h00);
  endtask

  task automatic test_random_sessions();
    logic [31:0] limits [4];
    int goal;
    limits[0] = $urandom_range(4, 40);
    limits[1] = 32'hffff_ffff;
    limits[2] = $urandom | 32'h100;
    limits[3] = $urandom_range(1, 3);
    foreach (limits[p]) begin
      write_limit(limits[p]);
      goal = stim_items + 50;
      while (stim_items < goal) run_session();
    end
  endtask

  task automatic test_full_rate();
    int goal;
    idle_on = 1'b0;
    write_limit(32'd64);
    goal = stim_items + 40;
    while (stim_items < goal) run_session();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_limit();
    test_limit_extremes();
    test_random_sessions();
    test_full_rate();
    wait_drained();
    $display("%0d transactions driven, %0d results checked, %0d limit settings",
             stim_items, results_checked, limits_used);
    $display("sizes rejected and accepted, aborted and overrun payloads, stalls on both sides");
    if (error_count == 0) begin
      $display("PASS serial_boot_receiver_unit");
    end else begin
      $display("FAIL serial_boot_receiver_unit");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_replies.size());
    $display("FAIL serial_boot_receiver_unit");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
sv/sbr_pkg.sv
sv/sbr_core.sv
sv/sbr_emitter.sv
sv/serial_boot_receiver_unit.sv
tb/tb_serial_boot_receiver_unit.sv
